@@ rtl/core/whpe_pkg.sv @@
// ----------------------------------------------------------------------------
// whpe_pkg
// types, codes and constants shared by the wav header parser and extractor
// ----------------------------------------------------------------------------
`default_nettype none

package whpe_pkg;

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 112;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;

  typedef enum logic [2:0] {
    PH_HDR,
    PH_FMTX,
    PH_ID,
    PH_SIZE,
    PH_DSIZE,
    PH_SKIP,
    PH_DATA,
    PH_HALT
  } phase_t;

  typedef logic [3:0] status_t;

  localparam status_t ST_OK       = 4'd0;
  localparam status_t ST_SHORT    = 4'd1;
  localparam status_t ST_RIFF     = 4'd2;
  localparam status_t ST_WAVE     = 4'd3;
  localparam status_t ST_FMT_TAG  = 4'd4;
  localparam status_t ST_FMT_SIZE = 4'd5;
  localparam status_t ST_NOT_PCM  = 4'd6;
  localparam status_t ST_NO_DATA  = 4'd7;
  localparam status_t ST_RATE     = 4'd8;
  localparam status_t ST_CHANNELS = 4'd9;
  localparam status_t ST_BITS     = 4'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE_MIN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_MAX      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS_MAX  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BITS_REQUIRED = 2'd3;

  localparam logic [31:0] RATE_MIN_RST      = 32'd8000;
  localparam logic [31:0] RATE_MAX_RST      = 32'd48000;
  localparam logic [15:0] CHANNELS_MAX_RST  = 16'd2;
  localparam logic [15:0] BITS_REQUIRED_RST = 16'd16;

  // "data" read little-endian
  localparam logic [31:0] DATA_ID  = 32'h6174_6164;
  localparam logic [31:0] FMT_BASE = 32'd16;
  localparam logic [15:0] PCM_CODE = 16'd1;

  // byte position saturates, only the header offsets and the minimum size matter
  localparam logic [5:0] POS_MAX  = 6'd63;
  localparam logic [5:0] MIN_FILE = 6'd44;
  localparam logic [5:0] HDR_END  = 6'd35;

  typedef struct packed {
    logic [31:0] rate_min;
    logic [31:0] rate_max;
    logic [15:0] channels_max;
    logic [15:0] bits_required;
  } limits_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        report_valid;
    status_t     status;
    logic [31:0] sample_rate;
    logic [15:0] channel_count;
    logic [15:0] bits_per_sample;
    logic [31:0] payload_count;
  } result_t;

  // "RIFF" "WAVE" "fmt "
  function automatic logic [7:0] tag_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h52;
      4'd1:    c = 8'h49;
      4'd2:    c = 8'h46;
      4'd3:    c = 8'h46;
      4'd4:    c = 8'h57;
      4'd5:    c = 8'h41;
      4'd6:    c = 8'h56;
      4'd7:    c = 8'h45;
      4'd8:    c = 8'h66;
      4'd9:    c = 8'h6d;
      4'd10:   c = 8'h74;
      4'd11:   c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/whpe_parser.sv @@
// ----------------------------------------------------------------------------
// whpe_parser
// per-byte header parse, chunk walk and payload gating with file state
// ----------------------------------------------------------------------------
`default_nettype none

module whpe_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  whpe_pkg::limits_t limits,
  output logic              result_valid,
  output whpe_pkg::result_t result
);
  import whpe_pkg::*;

  phase_t      phase, phase_next;
  logic [5:0]  pos, pos_next;
  logic [1:0]  lane, lane_next;
  logic [31:0] fmt_length, fmt_length_next;
  logic [31:0] chunk_remaining, chunk_remaining_next;
  logic [31:0] rate_seen, rate_seen_next;
  logic [15:0] channels_seen, channels_seen_next;
  logic [15:0] bits_seen, bits_seen_next;
  logic [31:0] data_remaining, data_remaining_next;
  logic [31:0] delivered_count, delivered_count_next;
  status_t     error_code, error_code_next;
  logic        pv;

  assign pv = (phase == PH_DATA) && (data_remaining != 32'd0);

  // next state and file fields
  always_comb begin
    phase_next           = phase;
    pos_next             = (pos == POS_MAX) ? pos : pos + 6'd1;
    lane_next            = lane;
    fmt_length_next      = fmt_length;
    chunk_remaining_next = chunk_remaining;
    rate_seen_next       = rate_seen;
    channels_seen_next   = channels_seen;
    bits_seen_next       = bits_seen;
    data_remaining_next  = data_remaining;
    delivered_count_next = delivered_count;
    error_code_next      = error_code;

    case (phase)
      PH_HDR: begin
        if (pos < 6'd4) begin
          if (in_byte != tag_char(pos[3:0])) begin
            error_code_next = ST_RIFF;
            phase_next      = PH_HALT;
          end
        end else if (pos >= 6'd8 && pos < 6'd16) begin
          if (in_byte != tag_char(pos[3:0] - 4'd4)) begin
            error_code_next = (pos < 6'd12) ? ST_WAVE : ST_FMT_TAG;
            phase_next      = PH_HALT;
          end
        end else if (pos >= 6'd16 && pos < 6'd20) begin
          fmt_length_next[{pos[1:0], 3'b000} +: 8] = in_byte;
          if (pos == 6'd19 && fmt_length_next < FMT_BASE) begin
            error_code_next = ST_FMT_SIZE;
            phase_next      = PH_HALT;
          end
        end else if (pos == 6'd20 || pos == 6'd21) begin
          // format code collects in the chunk counter
          chunk_remaining_next[{pos[1:0], 3'b000} +: 8] = in_byte;
          if (pos == 6'd21 && chunk_remaining_next != {16'd0, PCM_CODE}) begin
            error_code_next = ST_NOT_PCM;
            phase_next      = PH_HALT;
          end
        end else if (pos == 6'd22 || pos == 6'd23) begin
          channels_seen_next[{pos[0], 3'b000} +: 8] = in_byte;
        end else if (pos >= 6'd24 && pos < 6'd28) begin
          rate_seen_next[{pos[1:0], 3'b000} +: 8] = in_byte;
        end else if (pos == 6'd34 || pos == HDR_END) begin
          bits_seen_next[{pos[0], 3'b000} +: 8] = in_byte;
          if (pos == HDR_END) begin
            chunk_remaining_next = fmt_length - FMT_BASE;
            lane_next            = 2'd0;
            phase_next           = (chunk_remaining_next != 32'd0) ? PH_FMTX : PH_ID;
          end
        end
      end
      PH_FMTX, PH_SKIP: begin
        chunk_remaining_next = chunk_remaining - 32'd1;
        if (chunk_remaining_next == 32'd0) begin
          phase_next = PH_ID;
          lane_next  = 2'd0;
        end
      end
      PH_ID: begin
        chunk_remaining_next[{lane, 3'b000} +: 8] = in_byte;
        lane_next = lane + 2'd1;
        if (lane == 2'd3) begin
          phase_next           = (chunk_remaining_next == DATA_ID) ? PH_DSIZE : PH_SIZE;
          chunk_remaining_next = 32'd0;
          data_remaining_next  = 32'd0;
        end
      end
      PH_SIZE: begin
        chunk_remaining_next[{lane, 3'b000} +: 8] = in_byte;
        lane_next = lane + 2'd1;
        if (lane == 2'd3) begin
          phase_next = (chunk_remaining_next != 32'd0) ? PH_SKIP : PH_ID;
        end
      end
      PH_DSIZE: begin
        data_remaining_next[{lane, 3'b000} +: 8] = in_byte;
        lane_next = lane + 2'd1;
        if (lane == 2'd3) begin
          phase_next = PH_DATA;
          if (rate_seen < limits.rate_min || rate_seen > limits.rate_max) begin
            error_code_next = ST_RATE;
            phase_next      = PH_HALT;
          end else if (channels_seen == 16'd0 || channels_seen > limits.channels_max) begin
            error_code_next = ST_CHANNELS;
            phase_next      = PH_HALT;
          end else if (bits_seen != limits.bits_required) begin
            error_code_next = ST_BITS;
            phase_next      = PH_HALT;
          end
        end
      end
      PH_DATA: begin
        if (pv) begin
          data_remaining_next  = data_remaining - 32'd1;
          delivered_count_next = delivered_count + 32'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // result word
  always_comb begin
    result_valid         = step && (pv || in_last);
    result               = '0;
    result.payload_valid = pv;
    result.payload_byte  = pv ? in_byte : 8'd0;
    result.report_valid  = in_last;
    if (in_last) begin
      if (pos_next < MIN_FILE) begin
        result.status = ST_SHORT;
      end else if (error_code_next != ST_OK) begin
        result.status = error_code_next;
      end else if (phase_next != PH_DATA) begin
        result.status = ST_NO_DATA;
      end else begin
        result.status = ST_OK;
      end
      result.sample_rate     = rate_seen_next;
      result.channel_count   = channels_seen_next;
      result.bits_per_sample = bits_seen_next;
      result.payload_count   = delivered_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && in_last)) begin
      phase           <= PH_HDR;
      pos             <= 6'd0;
      lane            <= 2'd0;
      fmt_length      <= 32'd0;
      chunk_remaining <= 32'd0;
      rate_seen       <= 32'd0;
      channels_seen   <= 16'd0;
      bits_seen       <= 16'd0;
      data_remaining  <= 32'd0;
      delivered_count <= 32'd0;
      error_code      <= ST_OK;
    end else if (step) begin
      phase           <= phase_next;
      pos             <= pos_next;
      lane            <= lane_next;
      fmt_length      <= fmt_length_next;
      chunk_remaining <= chunk_remaining_next;
      rate_seen       <= rate_seen_next;
      channels_seen   <= channels_seen_next;
      bits_seen       <= bits_seen_next;
      data_remaining  <= data_remaining_next;
      delivered_count <= delivered_count_next;
      error_code      <= error_code_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/wav_header_parse_extract.sv @@
// output: a result word is registered and shows on m_tvalid in the cycle after its input byte is taken
// throughput: one byte per cycle while s_tready is high; the output register frees in the same cycle it drains
// s_tready drops only while a result waits and m_tready is low
// reset: synchronous, clears the parse state and output valid, limits return to
// 8000..48000 hz, two channels, 16 bits
// ----------------------------------------------------------------------------
// wav_header_parse_extract
// streaming wav header check with pcm payload pass-through and end-of-file report
// ----------------------------------------------------------------------------
`default_nettype none

module wav_header_parse_extract (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [whpe_pkg::IN_DATA_W-1:0]       s_tdata,   // [7:0] in_byte
  input  logic                                 s_tlast,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [7:0] payload_byte, [11:8] status, [43:12] sample_rate, [59:44] channel_count,
  // [75:60] bits_per_sample, [107:76] payload_count, [111:108] zero
  output logic [whpe_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic                                 m_tuser,   // [0] payload_valid
  output logic                                 m_tlast,
  input  logic                                 cfg_we,
  input  logic [whpe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [whpe_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import whpe_pkg::*;

  limits_t limits;
  result_t res;
  logic    res_valid;
  logic    s_accept;

  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.rate_min      <= RATE_MIN_RST;
      limits.rate_max      <= RATE_MAX_RST;
      limits.channels_max  <= CHANNELS_MAX_RST;
      limits.bits_required <= BITS_REQUIRED_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RATE_MIN:      limits.rate_min      <= cfg_data;
        CFG_RATE_MAX:      limits.rate_max      <= cfg_data;
        CFG_CHANNELS_MAX:  limits.channels_max  <= cfg_data[15:0];
        CFG_BITS_REQUIRED: limits.bits_required <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  whpe_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (s_accept),
    .in_byte      (s_tdata),
    .in_last      (s_tlast),
    .limits       (limits),
    .result_valid (res_valid),
    .result       (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept && res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept && res_valid) begin
      m_tdata <= {4'd0, res.payload_count, res.bits_per_sample, res.channel_count,
                  res.sample_rate, res.status, res.payload_byte};
      m_tuser <= res.payload_valid;
      m_tlast <= res.report_valid;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/whpe_checker.sv @@
// ----------------------------------------------------------------------------
// whpe_checker
// port-level checks on the result stream, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module whpe_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [whpe_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            m_tuser,
  input logic                            m_tlast
);
  import whpe_pkg::*;

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result word changed under stall");

  // every word carries a payload byte or a report
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser || m_tlast)
    else $error("empty result word");

  // report fields are zero outside the report word
  a_no_report: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[OUT_DATA_W-1:8] == '0)
    else $error("report fields set without report");

  // payload byte is zero when no audio byte rides along
  a_no_payload: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'd0)
    else $error("payload byte set without payload");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[11:8] <= ST_BITS)
    else $error("status code out of range");

endmodule

bind wav_header_parse_extract whpe_checker u_whpe_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire
